/* design/spmc_pkg.sv */
package spmc_pkg;

    localparam int unsigned MAX_LABELS_DEF = 1024;
    localparam int unsigned COUNT_BITS_DEF = 20;
    localparam int unsigned LABEL_W        = 10;
    localparam int unsigned COLOR_W        = 8;
    localparam int unsigned CFG_W          = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [1:0] {
        MODE_ACCUM = 2'd0,
        MODE_PAINT = 2'd1,
        MODE_FRAME = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

/* design/spmc_ram.sv */
module spmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/superpixel_mean_color.sv */
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: label[9:0], blue, green, red; tuser: mode[1:0]
// m_axis    out        tdata: mean_blue, mean_green, mean_red; tuser: label_valid
// cfg       in         i_cfg_data: labels_in_use[10:0]
//
// One item at a time. Accumulate reads the memory entry, then writes it back
// unless the count is saturated. Paint reads the entry, runs the bit-serial
// divider and loads the output register; it waits there while a previous result is not taken.
// New frame sweeps the memory to zero; reset starts the
// same sweep, and no word is accepted until it ends.
module superpixel_mean_color
    import spmc_pkg::*;
#(
    parameter int unsigned MAX_LABELS = MAX_LABELS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,   // label, blue_in, green_in, red_in
    input  logic [1:0]       s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // mean_blue, mean_green, mean_red
    output logic             m_axis_tuser,   // label_valid
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_LABELS);
    localparam int unsigned SW = COUNT_BITS + COLOR_W;
    localparam int unsigned EW = 3 * SW + COUNT_BITS;
    localparam int unsigned XW = (AW > LABEL_W ? AW : LABEL_W) + 1;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_LABELS);

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_cfg;
    logic [AW-1:0]         r_addr, n_addr;
    t_mode                 r_mode, n_mode;
    logic [COLOR_W-1:0]    r_b, r_g, r_r, n_b, n_g, n_r;
    logic [SW-1:0]         r_rem [3];
    logic [SW-1:0]         n_rem [3];
    logic [SW-1:0]         r_den, n_den;
    logic [COLOR_W-1:0]    r_q [3];
    logic [COLOR_W-1:0]    n_q [3];
    logic [2:0]            r_step, n_step;
    logic                  r_qv, n_qv;
    logic                  r_out_valid, n_out_valid;
    logic [23:0]           r_out_data, n_out_data;
    logic                  r_out_user, n_out_user;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [EW-1:0]         ram_wdata, ram_rdata;

    logic [LABEL_W-1:0]    in_label;
    logic [XW-1:0]         label_x, cfg_x;
    logic [LABEL_W+AW-1:0] label_ext;
    logic [SW-1:0]         sum_b, sum_g, sum_r, trial;
    logic [COUNT_BITS-1:0] cnt;

    assign in_label  = s_axis_tdata[LABEL_W-1:0];
    assign label_x   = XW'(in_label);
    assign cfg_x     = XW'(r_cfg);
    assign label_ext = {{AW{1'b0}}, in_label};
    assign ram_raddr = label_ext[AW-1:0];

    assign sum_b = ram_rdata[SW-1:0];
    assign sum_g = ram_rdata[2*SW-1:SW];
    assign sum_r = ram_rdata[3*SW-1:2*SW];
    assign cnt   = ram_rdata[EW-1:3*SW];
    assign trial = r_den << r_step;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    spmc_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_LABELS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_mode      = r_mode;
        n_b         = r_b;
        n_g         = r_g;
        n_r         = r_r;
        n_rem       = r_rem;
        n_den       = r_den;
        n_q         = r_q;
        n_step      = r_step;
        n_qv        = r_qv;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(MAX_LABELS - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_addr = ram_raddr;
                    n_mode = t_mode'(s_axis_tuser);
                    n_b    = s_axis_tdata[LABEL_W +: COLOR_W];
                    n_g    = s_axis_tdata[LABEL_W+COLOR_W +: COLOR_W];
                    n_r    = s_axis_tdata[LABEL_W+2*COLOR_W +: COLOR_W];
                    n_qv   = 1'b0;
                    n_q    = '{default: '0};
                    unique case (t_mode'(s_axis_tuser))
                        MODE_ACCUM: begin
                            if (label_x < MAX_X) begin
                                n_state = ST_READ;
                            end
                        end
                        MODE_PAINT: begin
                            // Out-of-range labels go straight to a black result.
                            if (label_x < MAX_X && label_x < cfg_x) begin
                                n_state = ST_READ;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        MODE_FRAME: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_mode == MODE_ACCUM) begin
                    n_state = ST_IDLE;
                    // A saturated count freezes the whole entry.
                    if (!(&cnt)) begin
                        ram_we    = 1'b1;
                        ram_wdata = {cnt + 1'b1,
                                     sum_r + SW'(r_r),
                                     sum_g + SW'(r_g),
                                     sum_b + SW'(r_b)};
                    end
                end else begin
                    n_rem[0] = sum_b;
                    n_rem[1] = sum_g;
                    n_rem[2] = sum_r;
                    n_den    = SW'(cnt);
                    n_step   = 3'd7;
                    if (cnt != '0) begin
                        n_qv    = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                // Restoring division; the quotient fits in eight bits because
                // every sum stays below 256 times its count.
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= trial) begin
                        n_rem[k]         = r_rem[k] - trial;
                        n_q[k][r_step]   = 1'b1;
                    end
                end
                n_step = r_step - 1'b1;
                if (r_step == 3'd0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_q[2], r_q[1], r_q[0]};
                    n_out_user  = r_qv;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_b        <= n_b;
        r_g        <= n_g;
        r_r        <= n_r;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_q        <= n_q;
        r_step     <= n_step;
        r_qv       <= n_qv;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule

/* tb/superpixel_mean_color_tb.sv */
`timescale 1ns / 100ps

module superpixel_mean_color_tb;
    import spmc_pkg::*;

    localparam int unsigned NLAB      = MAX_LABELS_DEF;
    localparam int unsigned CNT_W     = COUNT_BITS_DEF;
    localparam int unsigned SUM_W     = COLOR_W + CNT_W;
    localparam int unsigned IDLE_LIMIT = 20000;
    // A new frame sweeps the whole memory, so allow that much quiet time.
    localparam int unsigned SETTLE    = NLAB + 100;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               valid;
    } t_mean;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [39:0]      s_axis_tdata = '0;   // label, blue_in, green_in, red_in
    logic [1:0]       s_axis_tuser = '0;   // mode
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;        // mean_blue, mean_green, mean_red
    logic             m_axis_tuser;        // label_valid
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    superpixel_mean_color uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the block's label memory.
    logic [SUM_W-1:0] blue_acc [NLAB];
    logic [SUM_W-1:0] green_acc [NLAB];
    logic [SUM_W-1:0] red_acc [NLAB];
    logic [CNT_W-1:0] pix_cnt [NLAB];
    logic             entry_tag [NLAB];
    logic             cur_parity;
    logic [CFG_W-1:0] label_limit;

    t_mean pending_means[$];
    int    errors = 0;
    int    stall_left = 0;
    bit    gaps_on = 1'b1;
    int    idle_cycles = 0;
    // The test raises the request count; the receiver process starts the long hold.
    int    hold_requests = 0;
    int    hold_seen = 0;

    task automatic model_pixel(input t_mode mode, input logic [LABEL_W-1:0] label,
                               input logic [7:0] b, input logic [7:0] g,
                               input logic [7:0] r);
        t_mean m;
        m = '0;
        case (mode)
            MODE_ACCUM: begin
                if (entry_tag[label] != cur_parity) begin
                    blue_acc[label] = '0;
                    green_acc[label] = '0;
                    red_acc[label] = '0;
                    pix_cnt[label] = '0;
                    entry_tag[label] = cur_parity;
                end
                if (pix_cnt[label] != {CNT_W{1'b1}}) begin
                    blue_acc[label] += b;
                    green_acc[label] += g;
                    red_acc[label] += r;
                    pix_cnt[label] += 1'b1;
                end
            end
            MODE_PAINT: begin
                if (label < label_limit && entry_tag[label] == cur_parity
                    && pix_cnt[label] != 0) begin
                    m.blue = COLOR_W'(blue_acc[label] / pix_cnt[label]);
                    m.green = COLOR_W'(green_acc[label] / pix_cnt[label]);
                    m.red = COLOR_W'(red_acc[label] / pix_cnt[label]);
                    m.valid = 1'b1;
                end
                pending_means.insert(pending_means.size(), m);
            end
            MODE_FRAME: begin
                for (int i = 0; i < NLAB; i++) begin
                    blue_acc[i] = '0;
                    green_acc[i] = '0;
                    red_acc[i] = '0;
                    pix_cnt[i] = '0;
                end
                cur_parity = ~cur_parity;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_pixel(input t_mode mode, input logic [LABEL_W-1:0] label,
                              input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {6'b0, r, g, b, label};
        do @(posedge i_clk); while (!s_axis_tready);
        model_pixel(mode, label, b, g, r);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        stop_sending();
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_label_limit(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        label_limit = value > NLAB ? CFG_W'(NLAB) : value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(input int count, input int hot_labels);
        int    r;
        t_mode mode;
        logic [LABEL_W-1:0] label;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            mode = r < 55 ? MODE_ACCUM : r < 94 ? MODE_PAINT : r < 96 ? MODE_FRAME
                   : MODE_NONE;
            if ($urandom_range(0, 99) < 70)
                label = LABEL_W'($urandom_range(0, hot_labels - 1));
            else
                label = LABEL_W'($urandom);
            send_pixel(mode, label, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_pixel(MODE_PAINT, 10'd0, 8'd0, 8'd0, 8'd0);          // empty label
        send_pixel(MODE_ACCUM, 10'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(MODE_ACCUM, 10'd1023, 8'h00, 8'h00, 8'h00);
        send_pixel(MODE_PAINT, 10'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_PAINT, 10'd1023, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_ACCUM, 10'd5, 8'd1, 8'd200, 8'd255);
        send_pixel(MODE_ACCUM, 10'd5, 8'd2, 8'd3, 8'd254);
        send_pixel(MODE_ACCUM, 10'd5, 8'd2, 8'd7, 8'd0);
        send_pixel(MODE_PAINT, 10'd5, 8'h55, 8'hAA, 8'h0F);      // truncating mean
        send_pixel(MODE_NONE, 10'd5, 8'hFF, 8'hFF, 8'hFF);       // unused mode
        send_pixel(MODE_PAINT, 10'd5, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_ACCUM, 10'h2AA, 8'hAA, 8'h55, 8'hF0);
        send_pixel(MODE_ACCUM, 10'h155, 8'h55, 8'hAA, 8'h0F);
        send_pixel(MODE_PAINT, 10'h2AA, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_PAINT, 10'h155, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_FRAME, 10'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_PAINT, 10'd0, 8'd0, 8'd0, 8'd0);         // cleared by new frame
        send_pixel(MODE_PAINT, 10'd5, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_ACCUM, 10'd5, 8'd9, 8'd8, 8'd7);
        send_pixel(MODE_PAINT, 10'd5, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_FRAME, 10'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_FRAME, 10'd0, 8'd0, 8'd0, 8'd0);         // two frames back
        send_pixel(MODE_PAINT, 10'd5, 8'd0, 8'd0, 8'd0);
        stop_sending();
    endtask

    // Out-of-range labels still accumulate but paint black.
    task automatic test_label_limit();
        write_label_limit(11'd0);
        send_pixel(MODE_ACCUM, 10'd3, 8'd10, 8'd20, 8'd30);
        send_pixel(MODE_PAINT, 10'd3, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_PAINT, 10'd0, 8'd0, 8'd0, 8'd0);
        write_label_limit(11'd4);
        send_pixel(MODE_PAINT, 10'd3, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_ACCUM, 10'd4, 8'd1, 8'd1, 8'd1);
        send_pixel(MODE_PAINT, 10'd4, 8'd0, 8'd0, 8'd0);
        send_random(60, 8);
        write_label_limit(11'd2047);                               // acts as full range
        send_pixel(MODE_PAINT, 10'd4, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_ACCUM, 10'd1023, 8'd77, 8'd88, 8'd99);
        send_pixel(MODE_PAINT, 10'd1023, 8'd0, 8'd0, 8'd0);
        send_random(60, 16);
        write_label_limit(11'd1023);
        send_pixel(MODE_PAINT, 10'd1023, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_PAINT, 10'd1022, 8'd0, 8'd0, 8'd0);
        send_random(60, 1024);
        write_label_limit(11'd1024);
        stop_sending();
    endtask

    task automatic test_random_stream();
        gaps_on = 1'b1;
        send_random(200, 12);
        gaps_on = 1'b0;
        send_random(100, 32);
        gaps_on = 1'b1;
        send_random(150, 64);
        stop_sending();
    endtask

    // The receiver holds off for a long time while paints keep coming.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_requests++;
        for (int n = 0; n < 30; n++)
            send_pixel(MODE_PAINT, LABEL_W'($urandom_range(0, 15)), 8'd0, 8'd0, 8'd0);
        gaps_on = 1'b1;
        stop_sending();
    endtask

    always @(posedge i_clk) begin
        int r;
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            stall_left <= 3000;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!gaps_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                stall_left <= $urandom_range(10, 50);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= r < 75;
            end
        end
    end

    // Compare each word taken from the output with the oldest expected mean.
    always @(posedge i_clk) begin
        t_mean want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_means.size() == 0) begin
                $error("result word with nothing expected: %h/%b", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = pending_means.pop_front();
                if (m_axis_tdata[7:0] !== want.blue) begin
                    $error("mean_blue expected %0d got %0d", want.blue, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== want.green) begin
                    $error("mean_green expected %0d got %0d", want.green, m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== want.red) begin
                    $error("mean_red expected %0d got %0d", want.red, m_axis_tdata[23:16]);
                    errors++;
                end
                if (m_axis_tuser !== want.valid) begin
                    $error("label_valid expected %0d got %0d", want.valid, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NLAB; i++) begin
            blue_acc[i] = '0;
            green_acc[i] = '0;
            red_acc[i] = '0;
            pix_cnt[i] = '0;
            entry_tag[i] = 1'b0;
        end
        cur_parity = 1'b0;
        label_limit = CFG_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_label_limit();
        test_random_stream();
        test_backpressure();

        wait_idle();
        if (errors == 0 && pending_means.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* superpixel_mean_color.f */
design/spmc_pkg.sv
design/spmc_ram.sv
design/superpixel_mean_color.sv
tb/superpixel_mean_color_tb.sv
